[design/lapg_pkg.sv]
// Shared types, constants and lookup tables of the LED alert pattern generator.
`default_nettype none
package lapg_pkg;

  localparam int PIXEL_COUNT_DEF = 16;
  localparam int FRAME_FIFO_DEPTH_DEF = 2;

  localparam int ELAPSED_W = 8;
  localparam int SUM_W     = 7;
  localparam int PHASE_W   = 7;
  localparam int INDEX_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int ZONE_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam int FRAME_MS     = 100;
  localparam int PHASE_STEPS  = 100;
  localparam int FLASH_PERIOD = 20;
  localparam int FLASH_ON     = 10;
  localparam logic [COLOR_W-1:0] FULL_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_EVAC   = 2'd1,
    MODE_YELLOW = 2'd2,
    MODE_FLASH  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE = 2'd1;

  // One queued frame: pulse brightness and whether the flash is lit.
  typedef struct packed {
    logic [COLOR_W-1:0] bright;
    logic               flash_lit;
  } frame_t;

  localparam logic [COLOR_W-1:0] PULSE_ROM [0:PHASE_STEPS-1] = '{
    8'd128, 8'd135, 8'd143, 8'd151, 8'd159, 8'd167, 8'd174, 8'd182, 8'd189, 8'd196,
    8'd202, 8'd208, 8'd214, 8'd220, 8'd225, 8'd230, 8'd235, 8'd239, 8'd242, 8'd246,
    8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd252, 8'd251,
    8'd248, 8'd246, 8'd242, 8'd239, 8'd235, 8'd230, 8'd225, 8'd220, 8'd215, 8'd209,
    8'd202, 8'd196, 8'd189, 8'd182, 8'd174, 8'd167, 8'd159, 8'd151, 8'd144, 8'd136,
    8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd88,  8'd81,  8'd74,  8'd67,  8'd60,
    8'd53,  8'd47,  8'd41,  8'd35,  8'd30,  8'd25,  8'd20,  8'd16,  8'd13,  8'd10,
    8'd7,   8'd5,   8'd3,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd3,   8'd4,
    8'd7,   8'd9,   8'd12,  8'd16,  8'd20,  8'd25,  8'd29,  8'd35,  8'd40,  8'd46,
    8'd53,  8'd59,  8'd66,  8'd73,  8'd80,  8'd88,  8'd96,  8'd103, 8'd111, 8'd119
  };

  function automatic logic [COLOR_W-1:0] pulse_level(input logic [PHASE_W-1:0] p);
    logic [COLOR_W-1:0] v;
    v = '0;
    if (p < PHASE_W'(PHASE_STEPS)) begin
      v = PULSE_ROM[p];
    end
    return v;
  endfunction

  // The flash is lit during the first half of every flash period.
  function automatic logic flash_lit_at(input logic [PHASE_W-1:0] p);
    logic lit;
    lit = 1'b0;
    for (int k = 0; k < PHASE_STEPS / FLASH_PERIOD; k++) begin
      if (p >= PHASE_W'(k * FLASH_PERIOD) && p < PHASE_W'(k * FLASH_PERIOD + FLASH_ON)) begin
        lit = 1'b1;
      end
    end
    return lit;
  endfunction

endpackage
`default_nettype wire

[design/led_alert_pattern_generator.sv]
// Top level of the LED alert pattern generator: configuration registers, front end, queue, back end.
//
//   Channel   Handshake             Beat contents
//   ticks     push / full           elapsed_ms
//   pixels    empty / pop           pixel_index, red, green, blue, last_pixel
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick is taken while the queue is not full and, when it completes a frame period, queues one frame entry.
// The back end sends one pixel beat per cycle while pop is held; a frame spans PIXEL_COUNT beats,
// counted by its single pixel counter; ticks keep flowing until the frame queue fills.
// Reset clears the mode, zone, time sum, phase, queue and output valid flag.
// A stalled pop holds the output register and, once the queue is full, raises full.
`default_nettype none
module led_alert_pattern_generator #(
  parameter int PIXEL_COUNT      = lapg_pkg::PIXEL_COUNT_DEF,
  parameter int FRAME_FIFO_DEPTH = lapg_pkg::FRAME_FIFO_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [lapg_pkg::ELAPSED_W-1:0]  elapsed_ms,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [lapg_pkg::INDEX_W-1:0]         pixel_index,
  output logic [lapg_pkg::COLOR_W-1:0]         red,
  output logic [lapg_pkg::COLOR_W-1:0]         green,
  output logic [lapg_pkg::COLOR_W-1:0]         blue,
  output logic                                 last_pixel,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lapg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lapg_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import lapg_pkg::*;

  mode_t             display_mode;
  logic [ZONE_W-1:0] evacuate_zone;

  logic   frm_push;
  frame_t frm_wr;
  logic   frm_full;
  logic   frm_pop;
  frame_t frm_rd;
  logic   frm_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode  <= MODE_OFF;
      evacuate_zone <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE: display_mode  <= mode_t'(cfg_data[1:0]);
        CFG_ZONE: evacuate_zone <= cfg_data[ZONE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lapg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .elapsed_ms (elapsed_ms),
    .full       (full),
    .frm_push   (frm_push),
    .frm_data   (frm_wr),
    .frm_full   (frm_full)
  );

  lapg_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (FRAME_FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (frm_push),
    .wr_data  (frm_wr),
    .rd_en    (frm_pop),
    .rd_data  (frm_rd),
    .is_full  (frm_full),
    .is_empty (frm_empty)
  );

  lapg_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .display_mode  (display_mode),
    .evacuate_zone (evacuate_zone),
    .frm_data      (frm_rd),
    .frm_empty     (frm_empty),
    .frm_pop       (frm_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_index   (pixel_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_pixel    (last_pixel)
  );

endmodule
`default_nettype wire

[design/lapg_fifo.sv]
// Small register queue that carries frame entries from the tick front end to the pixel back end.
`default_nettype none
module lapg_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  is_full,
  output logic                  is_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("frame queue count beyond depth");

  a_write_moves_count: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> count == $past(count) + CNT_W'(1))
    else $error("frame queue lost a write");

endmodule
`default_nettype wire

[design/lapg_front.sv]
// Tick front end: sums elapsed time, steps the animation phase and queues one entry per frame.
`default_nettype none
module lapg_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [lapg_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic                             full,
  output logic                             frm_push,
  output lapg_pkg::frame_t                 frm_data,
  input  wire logic                        frm_full
);
  import lapg_pkg::*;

  logic [SUM_W-1:0]   frame_time_sum;
  logic [PHASE_W-1:0] anim_phase;
  logic [PHASE_W-1:0] anim_phase_next;
  logic [ELAPSED_W:0] sum_wide;
  logic               accept;
  logic               frame_due;

  assign full      = frm_full;
  assign accept    = push && !frm_full;
  assign sum_wide  = (ELAPSED_W + 1)'(frame_time_sum) + (ELAPSED_W + 1)'(elapsed_ms);
  assign frame_due = (sum_wide >= (ELAPSED_W + 1)'(FRAME_MS));

  assign anim_phase_next = (anim_phase == PHASE_W'(PHASE_STEPS - 1)) ? '0
                                                                    : anim_phase + PHASE_W'(1);

  assign frm_push           = accept && frame_due;
  assign frm_data.bright    = pulse_level(anim_phase_next);
  assign frm_data.flash_lit = flash_lit_at(anim_phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time_sum <= '0;
      anim_phase     <= '0;
    end else if (accept) begin
      if (frame_due) begin
        // Any overshoot past the frame period is dropped.
        frame_time_sum <= '0;
        anim_phase     <= anim_phase_next;
      end else begin
        frame_time_sum <= sum_wide[SUM_W-1:0];
      end
    end
  end

  a_sum_below_frame: assert property (@(posedge clk) disable iff (rst)
    frame_time_sum < SUM_W'(FRAME_MS))
    else $error("frame time sum left its range");

  a_phase_steps: assert property (@(posedge clk) disable iff (rst)
    frm_push |=> anim_phase == $past(anim_phase_next))
    else $error("phase did not step with a frame");

endmodule
`default_nettype wire

[design/lapg_back.sv]
// Pixel back end: walks each queued frame over the strip and holds one result in an output register.
`default_nettype none
module lapg_back #(
  parameter int PIXEL_COUNT = lapg_pkg::PIXEL_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lapg_pkg::mode_t              display_mode,
  input  wire logic [lapg_pkg::ZONE_W-1:0]  evacuate_zone,
  input  wire lapg_pkg::frame_t             frm_data,
  input  wire logic                         frm_empty,
  output logic                              frm_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [lapg_pkg::INDEX_W-1:0]      pixel_index,
  output logic [lapg_pkg::COLOR_W-1:0]      red,
  output logic [lapg_pkg::COLOR_W-1:0]      green,
  output logic [lapg_pkg::COLOR_W-1:0]      blue,
  output logic                              last_pixel
);
  import lapg_pkg::*;

  localparam logic [INDEX_W-1:0] LAST_PIX = INDEX_W'(PIXEL_COUNT - 1);

  logic               busy;
  logic [INDEX_W-1:0] pix;
  frame_t             cur;
  logic               out_valid;

  logic               advance;
  logic               issue;
  frame_t             sel_frame;
  logic [INDEX_W-1:0] sel_pix;
  logic [COLOR_W-1:0] red_next;
  logic [COLOR_W-1:0] green_next;

  assign empty     = !out_valid;
  assign advance   = !out_valid || pop;
  assign issue     = advance && (busy || !frm_empty);
  assign frm_pop   = issue && !busy;
  assign sel_frame = busy ? cur : frm_data;
  assign sel_pix   = busy ? pix : '0;

  always_comb begin
    red_next   = '0;
    green_next = '0;
    case (display_mode)
      MODE_EVAC: begin
        if (ZONE_W'(sel_pix) < evacuate_zone) begin
          green_next = sel_frame.bright;
        end else begin
          red_next = FULL_LEVEL;
        end
      end
      MODE_YELLOW: begin
        red_next   = sel_frame.bright;
        green_next = sel_frame.bright;
      end
      MODE_FLASH: begin
        if (sel_frame.flash_lit) begin
          red_next = FULL_LEVEL;
        end
      end
      default: begin
        red_next   = '0;
        green_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= issue;
      if (issue) begin
        busy <= (sel_pix != LAST_PIX);
        pix  <= sel_pix + INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_pop) begin
      cur <= frm_data;
    end
    if (issue) begin
      pixel_index <= sel_pix;
      red         <= red_next;
      green       <= green_next;
      blue        <= '0;
      last_pixel  <= (sel_pix == LAST_PIX);
    end
  end

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> pixel_index == LAST_PIX)
    else $error("last pixel flag on the wrong pixel");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pix != '0 && pix <= LAST_PIX))
    else $error("pixel counter outside the frame while busy");

endmodule
`default_nettype wire

[tb/sv/tb_led_alert_pattern_generator.sv]
// Self-checking testbench for the LED alert pattern generator: tick stimulus, register writes, frame scoreboard.
`timescale 1ns / 100ps
module tb_led_alert_pattern_generator;
  import lapg_pkg::*;

  localparam int PIXELS = PIXEL_COUNT_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 35;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD3 = 2'd3;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               last;
  } pixel_t;

  // Tracks the time sum and phase, and holds the pixel beats still owed by the block.
  class frame_scoreboard;
    mode_t              mode;
    logic [ZONE_W-1:0]  zone;
    logic [SUM_W-1:0]   time_sum;
    logic [PHASE_W-1:0] phase;
    pixel_t             pending_pixels[$];
    int unsigned        errors;

    function new();
      mode = MODE_OFF;
      zone = '0;
      time_sum = '0;
      phase = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_MODE) begin
        mode = mode_t'(data[1:0]);
      end else if (idx == CFG_ZONE) begin
        zone = data[ZONE_W-1:0];
      end
    endfunction

    function void take_tick(logic [ELAPSED_W-1:0] ms);
      int unsigned total;
      logic [COLOR_W-1:0] level;
      logic lit;
      pixel_t px;
      total = int'(time_sum) + int'(ms);
      if (total < FRAME_MS) begin
        time_sum = SUM_W'(total);
        return;
      end
      // Any overshoot past the frame period is dropped.
      time_sum = '0;
      phase = PHASE_W'((int'(phase) + 1) % PHASE_STEPS);
      level = PULSE_ROM[phase];
      lit = (int'(phase) % FLASH_PERIOD) < FLASH_ON;
      for (int i = 0; i < PIXELS; i++) begin
        px = '0;
        px.index = INDEX_W'(i);
        px.last = (i == PIXELS - 1);
        case (mode)
          MODE_EVAC: begin
            if (i < int'(zone)) px.g = level;
            else px.r = FULL_LEVEL;
          end
          MODE_YELLOW: begin
            px.r = level;
            px.g = level;
          end
          MODE_FLASH: begin
            if (lit) px.r = FULL_LEVEL;
          end
          default: begin
          end
        endcase
        pending_pixels.push_back(px);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel beat, expected none, actual index %0d", $time,
                 got.index);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      check_field("pixel_index", want.index, got.index);
      check_field("red", want.r, got.r);
      check_field("green", want.g, got.g);
      check_field("blue", want.b, got.b);
      check_field("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [INDEX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0]   red;
  logic [COLOR_W-1:0]   green;
  logic [COLOR_W-1:0]   blue;
  logic                 last_pixel;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  frame_scoreboard board = new();
  logic hold_pop = 1'b0;
  int   send_run = 0;
  int   recv_run = 0;

  always #10 clk = ~clk;

  led_alert_pattern_generator dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .elapsed_ms  (elapsed_ms),
    .empty       (empty),
    .pop         (pop),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Mostly random gaps, with occasional runs of back-to-back beats.
  function automatic int draw_gap(ref int run_left);
    int gap;
    gap = 0;
    if (run_left > 0) begin
      run_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      run_left = 20;
    end else begin
      gap = $urandom_range(0, 9);
    end
    return gap;
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_ms();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return ELAPSED_W'($urandom_range(0, 40));
    else if (pick < 17) return ELAPSED_W'($urandom_range(100, 255));
    else return ELAPSED_W'($urandom_range(0, 255));
  endfunction

  task automatic send_tick(input logic [ELAPSED_W-1:0] ms);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    elapsed_ms <= ms;
    do @(posedge clk); while (full);
    board.take_tick(ms);
  endtask

  // Stops offering ticks and waits until every owed pixel has been taken.
  task automatic wait_idle();
    push <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  // The upper mode bits are random so that masking of the written value is exercised.
  task automatic set_pattern(input mode_t m, input logic [ZONE_W-1:0] z);
    wait_idle();
    write_cfg(CFG_MODE, {5'($urandom_range(0, 31)), 2'(m)});
    write_cfg(CFG_ZONE, z);
    if ($urandom_range(0, 2) == 0) begin
      write_cfg($urandom_range(0, 1) ? CFG_RSVD2 : CFG_RSVD3,
                CFG_DAT_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    logic [ELAPSED_W-1:0] off_ticks[11] = '{0, 99, 1, 255, 100, 50, 49, 0, 1, 128, 127};
    mode_t phase_modes[RANDOM_PHASES] = '{MODE_FLASH, MODE_EVAC, MODE_EVAC, MODE_EVAC,
                                          MODE_YELLOW, MODE_EVAC, MODE_OFF, MODE_FLASH};
    int phase_zones[RANDOM_PHASES] = '{-1, 0, 9, 16, 127, -1, -1, 64};
    logic [ZONE_W-1:0] z;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: all pixels off, exact frame period and overshoot; then each mode and zone edges.
    foreach (off_ticks[i]) send_tick(off_ticks[i]);
    set_pattern(MODE_YELLOW, 7'd0);
    send_tick(8'd255);
    send_tick(8'd200);
    wait_idle();
    write_cfg(CFG_MODE, 7'h7F);
    send_tick(8'd100);
    send_tick(8'd100);
    wait_idle();
    write_cfg(CFG_RSVD2, 7'h7F);
    write_cfg(CFG_RSVD3, 7'h55);
    send_tick(8'd100);
    set_pattern(MODE_EVAC, 7'd0);
    send_tick(8'd100);
    set_pattern(MODE_EVAC, 7'd15);
    send_tick(8'd100);
    set_pattern(MODE_EVAC, 7'd16);
    send_tick(8'd100);
    set_pattern(MODE_EVAC, 7'd127);
    send_tick(8'd100);
    set_pattern(MODE_EVAC, 7'd64);
    send_tick(8'd255);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      z = (phase_zones[p] < 0) ? ZONE_W'($urandom_range(0, 64)) : ZONE_W'(phase_zones[p]);
      set_pattern(phase_modes[p], z);
      // The receiver stalls long enough here for the frame queue to fill.
      if (p == 1) hold_pop = 1'b1;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (p == 3 && n == 17) wait_idle();
        send_tick(random_ms());
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending_pixels.size() == 0) begin
      $display("** led_alert_pattern_generator: PASSED **");
    end else begin
      $display("** led_alert_pattern_generator: FAILED **");
    end
    $finish;
  end

  initial begin
    pixel_t got;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_pop) begin
        hold_pop = 1'b0;
        gap = LONG_HOLD_CYCLES;
      end else begin
        gap = draw_gap(recv_run);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.index = pixel_index;
      got.r = red;
      got.g = green;
      got.b = blue;
      got.last = last_pixel;
      board.check_pixel(got);
    end
  end

  initial begin
    #20_000_000;
    $display("** led_alert_pattern_generator: FAILED **");
    $finish;
  end

endmodule
